### rtl/rcfh_pkg.sv
// ----------------------------------------------------------------------------
// rcfh_pkg
// Shared widths, register indexes and helpers of the checkered floor ray hit.
// ----------------------------------------------------------------------------
package rcfh_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned SqW    = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivQW  = 64;
  localparam int unsigned DistW  = 32;

  localparam logic [CfgIdxW-1:0] CFG_FLOOR_HEIGHT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SQUARE_SIZE  = 2'd1;

  // Stages from an accepted start to the result strobe.
  localparam int unsigned LatTotal = 3 + DivQW + 1 + DivQW + 1;

  typedef struct packed {
    logic              oneg;
    logic              dneg;
    logic [DataW-1:0]  om;
  } axis_t;

  function automatic logic [DataW-1:0] abs32(input logic [DataW-1:0] x);
    return x[DataW-1] ? (~x + 32'd1) : x;
  endfunction

  // Returns {positive, magnitude} of origin plus signed offset.
  function automatic logic [DivQW:0] fold(input axis_t a, input logic [DivQW-1:0] q);
    logic [DivQW-1:0] om64;
    logic [DivQW-1:0] mag;
    logic             neg;
    om64 = {32'd0, a.om};
    if (a.oneg == a.dneg) begin
      mag = om64 + q;
      neg = a.oneg;
    end else if (om64 >= q) begin
      mag = om64 - q;
      neg = a.oneg;
    end else begin
      mag = q - om64;
      neg = a.dneg;
    end
    return {(!neg) && (mag != '0), mag};
  endfunction

endpackage

### rtl/ray_checker_floor_hit_top.sv
// ----------------------------------------------------------------------------
// ray_checker_floor_hit_top
// Ray against checkered floor plane: hit flag, checker shade, hit distance.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  ray in    start & !busy        origin_x/y/z_i, dir_x/y/z_i
//  result    valid_o (one cycle)  hit_o, shade_o, distance_o
//  config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
//  One ray a cycle; busy stays low.
//  The path is a 64 stage divider for the hit point, then a 64 stage
//  remainder unit for the checker; the length root and distance divide run
//  alongside.
//  Reset clears valid bits and config; floor_height 0, square_size 1.0.
//  No stall: each result beat shows for one cycle.
// ----------------------------------------------------------------------------
module ray_checker_floor_hit_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [rcfh_pkg::DataW-1:0]    origin_x_i,
  input  logic [rcfh_pkg::DataW-1:0]    origin_y_i,
  input  logic [rcfh_pkg::DataW-1:0]    origin_z_i,
  input  logic [rcfh_pkg::DataW-1:0]    dir_x_i,
  input  logic [rcfh_pkg::DataW-1:0]    dir_y_i,
  input  logic [rcfh_pkg::DataW-1:0]    dir_z_i,
  input  logic                          cfg_we_i,
  input  logic [rcfh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rcfh_pkg::DataW-1:0]    cfg_wdata_i,
  output logic                          valid_o,
  output logic                          hit_o,
  output logic                          shade_o,
  output logic [rcfh_pkg::DistW-1:0]    distance_o
);

  import rcfh_pkg::*;

  logic [DataW-1:0] fh_q;
  logic [SqW-1:0]   ssz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q  <= '0;
      ssz_q <= SqW'(64'd1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLOOR_HEIGHT: fh_q  <= cfg_wdata_i;
        CFG_SQUARE_SIZE:  ssz_q <= cfg_wdata_i[SqW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: plane offset, hit test, magnitudes
  logic [DataW:0] num_c;
  logic [DataW:0] an_c;
  logic           hit_c;
  assign num_c = {fh_q[DataW-1], fh_q} - {origin_z_i[DataW-1], origin_z_i};
  assign an_c  = num_c[DataW] ? (~num_c + 33'd1) : num_c;
  assign hit_c = (dir_z_i != '0) && (num_c != '0) && (num_c[DataW] == dir_z_i[DataW-1]);

  logic             v1_q, hit1_q;
  logic [DataW:0]   an1_q;
  logic [DataW-1:0] adz1_q, adx1_q, ady1_q;
  axis_t            ax1_q, ay1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    hit1_q  <= hit_c;
    an1_q   <= an_c;
    adz1_q  <= abs32(dir_z_i);
    adx1_q  <= abs32(dir_x_i);
    ady1_q  <= abs32(dir_y_i);
    ax1_q   <= '{oneg: origin_x_i[DataW-1], dneg: dir_x_i[DataW-1], om: abs32(origin_x_i)};
    ay1_q   <= '{oneg: origin_y_i[DataW-1], dneg: dir_y_i[DataW-1], om: abs32(origin_y_i)};
  end

  // stage 2: products and squares
  logic             v2_q, hit2_q;
  logic [63:0]      px2_q, py2_q, sqx2_q, sqy2_q, sqz2_q;
  logic [DataW:0]   an2_q;
  logic [DataW-1:0] adz2_q;
  axis_t            ax2_q, ay2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit2_q <= hit1_q;
    px2_q  <= {32'd0, adx1_q} * {31'd0, an1_q};
    py2_q  <= {32'd0, ady1_q} * {31'd0, an1_q};
    sqx2_q <= {32'd0, adx1_q} * {32'd0, adx1_q};
    sqy2_q <= {32'd0, ady1_q} * {32'd0, ady1_q};
    sqz2_q <= {32'd0, adz1_q} * {32'd0, adz1_q};
    an2_q  <= an1_q;
    adz2_q <= adz1_q;
    ax2_q  <= ax1_q;
    ay2_q  <= ay1_q;
  end

  // stage 3: squared length
  logic             v3_q, hit3_q;
  logic [63:0]      px3_q, py3_q, sum3_q;
  logic [DataW:0]   an3_q;
  logic [DataW-1:0] adz3_q;
  axis_t            ax3_q, ay3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit3_q <= hit2_q;
    px3_q  <= px2_q;
    py3_q  <= py2_q;
    sum3_q <= sqx2_q + sqy2_q + sqz2_q;
    an3_q  <= an2_q;
    adz3_q <= adz2_q;
    ax3_q  <= ax2_q;
    ay3_q  <= ay2_q;
  end

  // hit point offsets
  logic              dx_v, dy_v;
  logic [DivQW-1:0]  dx_quo, dy_quo;
  logic [34:0]       dx_side;
  axis_t             dy_side;

  rcfh_div_pipe #(.N(DivQW), .D(DataW), .S(35)) u_div_x (
    .clk_i, .rst_ni,
    .valid_i (v3_q), .num_i (px3_q), .rem_i ('0), .den_i (adz3_q),
    .side_i  ({hit3_q, ax3_q}),
    .valid_o (dx_v), .quo_o (dx_quo), .rem_o (), .side_o (dx_side)
  );

  rcfh_div_pipe #(.N(DivQW), .D(DataW), .S(34)) u_div_y (
    .clk_i, .rst_ni,
    .valid_i (v3_q), .num_i (py3_q), .rem_i ('0), .den_i (adz3_q),
    .side_i  (ay3_q),
    .valid_o (dy_v), .quo_o (dy_quo), .rem_o (), .side_o (dy_side)
  );

  // direction length and distance
  logic             sq_v;
  logic [31:0]      sq_root;
  logic [64:0]      sq_side;

  rcfh_isqrt_pipe #(.W(64), .S(65)) u_isqrt (
    .clk_i, .rst_ni,
    .valid_i (v3_q), .rad_i (sum3_q), .side_i ({an3_q, adz3_q}),
    .valid_o (sq_v), .root_o (sq_root), .side_o (sq_side)
  );

  logic             m_v_q;
  logic [63:0]      m_p_q;
  logic [DataW-1:0] m_adz_q;
  logic             m_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else begin
      m_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    m_p_q   <= {32'd0, sq_root} * {31'd0, sq_side[64:32]};
    m_adz_q <= sq_side[31:0];
  end

  assign m_sat = m_p_q[63:32] >= m_adz_q;

  logic             dd_v;
  logic [DistW-1:0] dd_quo;
  logic             dd_sat;

  rcfh_div_pipe #(.N(DistW), .D(DataW), .S(1)) u_div_dist (
    .clk_i, .rst_ni,
    .valid_i (m_v_q), .num_i (m_p_q[31:0]), .rem_i (m_p_q[63:32]), .den_i (m_adz_q),
    .side_i  (m_sat),
    .valid_o (dd_v), .quo_o (dd_quo), .rem_o (), .side_o (dd_sat)
  );

  // hit point
  logic [DivQW:0]   fx_c, fy_c;
  logic             h_v_q, h_hit_q, h_sx_q, h_sy_q;
  logic [DivQW-1:0] h_mx_q, h_my_q;

  assign fx_c = fold(dx_side[33:0], dx_quo);
  assign fy_c = fold(dy_side, dy_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
    end else begin
      h_v_q <= dx_v;
    end
  end

  always_ff @(posedge clk_i) begin
    h_hit_q <= dx_side[34];
    h_sx_q  <= fx_c[DivQW];
    h_mx_q  <= fx_c[DivQW-1:0];
    h_sy_q  <= fy_c[DivQW];
    h_my_q  <= fy_c[DivQW-1:0];
  end

  // checker remainders
  logic             mx_v, my_v;
  logic [SqW-1:0]   rx, ry;
  logic [34:0]      mx_side;
  logic             my_side;

  rcfh_div_pipe #(.N(DivQW), .D(SqW), .S(35)) u_mod_x (
    .clk_i, .rst_ni,
    .valid_i (h_v_q), .num_i (h_mx_q), .rem_i ('0), .den_i (ssz_q),
    .side_i  ({h_hit_q, h_sx_q, dd_sat, dd_quo}),
    .valid_o (mx_v), .quo_o (), .rem_o (rx), .side_o (mx_side)
  );

  rcfh_div_pipe #(.N(DivQW), .D(SqW), .S(1)) u_mod_y (
    .clk_i, .rst_ni,
    .valid_i (h_v_q), .num_i (h_my_q), .rem_i ('0), .den_i (ssz_q),
    .side_i  (h_sy_q),
    .valid_o (my_v), .quo_o (), .rem_o (ry), .side_o (my_side)
  );

  logic pivot_c, low_c, hit_f;
  assign pivot_c = {rx, 1'b0} < {1'b0, ssz_q};
  assign low_c   = {ry, 1'b0} < {1'b0, ssz_q};
  assign hit_f   = mx_side[34];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= mx_v;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o      <= hit_f;
    shade_o    <= hit_f && !(pivot_c ^ mx_side[33] ^ my_side ^ low_c);
    distance_o <= !hit_f ? '0 : (mx_side[32] ? '1 : mx_side[31:0]);
  end

  a_lanes_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dy_v == dx_v) && (my_v == mx_v))
    else $error("x and y lanes out of step");

  a_dist_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dd_v == h_v_q)
    else $error("distance path not aligned with hit point");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !hit_o |-> !shade_o && (distance_o == '0))
    else $error("miss beat carries nonzero payload");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(LatTotal) valid_o)
    else $error("result beat missing after fixed latency");

endmodule

### rtl/rcfh_div_pipe.sv
// ----------------------------------------------------------------------------
// rcfh_div_pipe
// Restoring divider, one quotient bit per register stage, with side data.
// ----------------------------------------------------------------------------
module rcfh_div_pipe #(
  parameter int unsigned N = 64,
  parameter int unsigned D = 32,
  parameter int unsigned S = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [N-1:0] num_i,
  input  logic [D-1:0] rem_i,
  input  logic [D-1:0] den_i,
  input  logic [S-1:0] side_i,
  output logic         valid_o,
  output logic [N-1:0] quo_o,
  output logic [D-1:0] rem_o,
  output logic [S-1:0] side_o
);

  logic [N-1:0] vld_q;
  logic [N-1:0] w_q [N];
  logic [D-1:0] r_q [N];
  logic [D-1:0] d_q [N];
  logic [S-1:0] s_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic         v_in;
    logic [N-1:0] w_in;
    logic [D-1:0] r_in;
    logic [D-1:0] d_in;
    logic [S-1:0] s_in;
    logic [D:0]   t;
    logic [D:0]   diff;
    logic         ge;

    if (k == 0) begin : g_head
      assign v_in = valid_i;
      assign w_in = num_i;
      assign r_in = rem_i;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_body
      assign v_in = vld_q[k-1];
      assign w_in = w_q[k-1];
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
      assign s_in = s_q[k-1];
    end

    assign t    = {r_in, w_in[N-1]};
    assign ge   = t >= {1'b0, d_in};
    assign diff = t - {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      w_q[k] <= {w_in[N-2:0], ge};
      r_q[k] <= ge ? diff[D-1:0] : t[D-1:0];
      d_q[k] <= d_in;
      s_q[k] <= s_in;
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = w_q[N-1];
  assign rem_o   = r_q[N-1];
  assign side_o  = s_q[N-1];

endmodule

### rtl/rcfh_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// rcfh_isqrt_pipe
// Integer square root, one root bit per register stage, with side data.
// ----------------------------------------------------------------------------
module rcfh_isqrt_pipe #(
  parameter int unsigned W = 64,
  parameter int unsigned S = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [W-1:0]   rad_i,
  input  logic [S-1:0]   side_i,
  output logic           valid_o,
  output logic [W/2-1:0] root_o,
  output logic [S-1:0]   side_o
);

  localparam int unsigned R = W / 2;

  logic [R-1:0] vld_q;
  logic [W-1:0] v_q    [R];
  logic [R-1:0] root_q [R];
  logic [R+1:0] rem_q  [R];
  logic [S-1:0] s_q    [R];

  for (genvar k = 0; k < R; k++) begin : g_stage
    logic         v_in;
    logic [W-1:0] rad_in;
    logic [R-1:0] root_in;
    logic [R+1:0] rem_in;
    logic [S-1:0] s_in;
    logic [R+3:0] t;
    logic [R+3:0] trial;
    logic [R+3:0] diff;
    logic         ge;

    if (k == 0) begin : g_head
      assign v_in    = valid_i;
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign s_in    = side_i;
    end else begin : g_body
      assign v_in    = vld_q[k-1];
      assign rad_in  = v_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign s_in    = s_q[k-1];
    end

    assign t     = {rem_in, rad_in[W-1:W-2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      v_q[k]    <= {rad_in[W-3:0], 2'b00};
      root_q[k] <= {root_in[R-2:0], ge};
      rem_q[k]  <= ge ? diff[R+1:0] : t[R+1:0];
      s_q[k]    <= s_in;
    end
  end

  assign valid_o = vld_q[R-1];
  assign root_o  = root_q[R-1];
  assign side_o  = s_q[R-1];

endmodule
